// ----- design/uat_pkg.sv -----
// Shared types and constants for the undirected adjacency table.
// Holds the operation codes and the command word passed from front to back.
// No dependencies.
package uat_pkg;

  localparam int ID_W = 8;

  localparam logic [1:0] OP_ADD_VERTEX    = 2'd0;
  localparam logic [1:0] OP_REMOVE_VERTEX = 2'd1;
  localparam logic [1:0] OP_ADD_EDGE      = 2'd2;
  localparam logic [1:0] OP_REMOVE_EDGE   = 2'd3;

  typedef logic [ID_W-1:0] vid_t;
  typedef logic [ID_W:0]   vid_ext_t;

  // Classified command: the range flags and the self-loop flag are worked out
  // in the front so that the back only has to consult the present bits.
  typedef struct packed {
    logic [1:0] op;
    vid_t       a;
    vid_t       b;
    logic       a_in;
    logic       b_in;
    logic       self_loop;
  } cmd_t;

endpackage

// ----- design/uat_front.sv -----
// Intake stage of the undirected adjacency table.
// Accepts items, classifies them into cmd_t words and holds one in a register.
// Depends on uat_pkg.
module uat_front
  import uat_pkg::*;
#(
  parameter int NUM_VERTICES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  vid_t       in_vertex_a,
  input  vid_t       in_vertex_b,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  localparam vid_ext_t NUM_IDS = vid_ext_t'(NUM_VERTICES);

  logic fr_valid_r, fr_valid_nxt;
  cmd_t fr_cmd_r;
  cmd_t cls_cmd;
  logic accept;

  assign in_ready = !fr_valid_r || cmd_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cls_cmd.op        = in_op;
    cls_cmd.a         = in_vertex_a;
    cls_cmd.b         = in_vertex_b;
    cls_cmd.a_in      = ({1'b0, in_vertex_a} < NUM_IDS);
    cls_cmd.b_in      = ({1'b0, in_vertex_b} < NUM_IDS);
    cls_cmd.self_loop = (in_vertex_a == in_vertex_b);
  end

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (cmd_ready) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_cmd_r <= cls_cmd;
    end
  end

  assign cmd_valid = fr_valid_r;
  assign cmd       = fr_cmd_r;

endmodule

// ----- design/uat_cmd_queue.sv -----
// Two-entry command queue between the intake stage and the execution engine.
// Lets either side stall without holding up the other.
// Depends on uat_pkg.
module uat_cmd_queue
  import uat_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam logic [1:0] QDEPTH = 2'd2;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign push_ready = (count_r != QDEPTH);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QDEPTH)
    else $error("command queue count beyond its depth");

  a_full_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == QDEPTH) |-> (wr_ptr_r == rd_ptr_r))
    else $error("command queue pointers disagree with its count");

endmodule

// ----- design/uat_back.sv -----
// Execution engine of the undirected adjacency table.
// Holds the present bits, the adjacency row memory and the result register.
// Depends on uat_pkg.
module uat_back
  import uat_pkg::*;
#(
  parameter int NUM_VERTICES = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic out_valid,
  input  logic out_ready,
  output logic out_ok
);

  localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam logic [AW-1:0] LAST_ROW = AW'(NUM_VERTICES - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EDGE_A = 4'b0010,
    S_EDGE_B = 4'b0100,
    S_SWEEP  = 4'b1000
  } state_t;

  typedef logic [NUM_VERTICES-1:0] row_t;

  state_t  state_r, state_nxt;
  cmd_t    cmd_r;
  row_t    present_r, present_nxt;
  row_t    row_valid_r;
  row_t    adj_mem_r [NUM_VERTICES];
  row_t    rd_row_r;
  logic    rd_vld_r;
  logic [AW-1:0] rd_addr_r;
  logic    out_valid_r, out_valid_nxt;
  logic    out_ok_r, out_ok_nxt;

  logic          slot_free, take;
  logic [AW-1:0] a_idx, b_idx, ea_idx, eb_idx;
  logic          pa, pb, add_ok, edge_set;
  row_t          rd_row, mask_a, mask_b;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  row_t          wr_row;

  assign slot_free = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE) && slot_free;
  assign take      = cmd_valid && cmd_ready;

  assign a_idx    = cmd.a[AW-1:0];
  assign b_idx    = cmd.b[AW-1:0];
  assign ea_idx   = cmd_r.a[AW-1:0];
  assign eb_idx   = cmd_r.b[AW-1:0];
  assign pa       = cmd.a_in && present_r[a_idx];
  assign pb       = cmd.b_in && present_r[b_idx];
  assign add_ok   = cmd.a_in && !present_r[a_idx];
  assign edge_set = (cmd_r.op == OP_ADD_EDGE);

  // A row that has never been written reads as all zero.
  assign rd_row = rd_vld_r ? rd_row_r : '0;

  always_comb begin
    mask_a         = '0;
    mask_a[ea_idx] = 1'b1;
    mask_b         = '0;
    mask_b[eb_idx] = 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    rd_en         = 1'b0;
    rd_addr       = a_idx;
    wr_en         = 1'b0;
    wr_addr       = rd_addr_r;
    wr_row        = rd_row;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_ADD_VERTEX: begin
              out_valid_nxt = 1'b1;
              out_ok_nxt    = add_ok;
              if (add_ok) begin
                present_nxt[a_idx] = 1'b1;
              end
            end
            OP_REMOVE_VERTEX: begin
              if (pa) begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_SWEEP;
              end else begin
                out_valid_nxt = 1'b1;
                out_ok_nxt    = 1'b0;
              end
            end
            default: begin
              if (pa && pb) begin
                rd_en     = 1'b1;
                rd_addr   = a_idx;
                state_nxt = S_EDGE_A;
              end else begin
                out_valid_nxt = 1'b1;
                out_ok_nxt    = 1'b0;
              end
            end
          endcase
        end
      end
      S_EDGE_A: begin
        wr_en  = 1'b1;
        wr_row = edge_set ? (rd_row | mask_b) : (rd_row & ~mask_b);
        if (cmd_r.self_loop) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = eb_idx;
          state_nxt = S_EDGE_B;
        end
      end
      S_EDGE_B: begin
        wr_en         = 1'b1;
        wr_row        = edge_set ? (rd_row | mask_a) : (rd_row & ~mask_a);
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SWEEP: begin
        // Each cycle writes back one row with the vertex's column bit cleared
        // while the next row is read; the vertex's own row is cleared whole.
        wr_en  = 1'b1;
        wr_row = (rd_addr_r == ea_idx) ? '0 : (rd_row & ~mask_a);
        if (rd_addr_r == LAST_ROW) begin
          present_nxt[ea_idx] = 1'b0;
          out_valid_nxt       = 1'b1;
          out_ok_nxt          = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_addr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= '0;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r <= out_ok_nxt;
    if (take) begin
      cmd_r <= cmd;
    end
    if (rd_en) begin
      rd_row_r  <= adj_mem_r[rd_addr];
      rd_vld_r  <= row_valid_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      adj_mem_r[wr_addr] <= wr_row;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;

  a_no_rw_same_row: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("row written and read in the same cycle");

  a_edge_b_after_a: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDGE_B) |-> ($past(state_r) == S_EDGE_A))
    else $error("second edge row written without the first");

  a_busy_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result pending while a command is in progress");

  a_sweep_clears_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && rd_addr_r == LAST_ROW) |=> !present_r[ea_idx])
    else $error("removed vertex still marked present");

endmodule

// ----- design/undirected_adjacency_table.sv -----
// Undirected graph store: present bit per vertex id and a symmetric adjacency
// bit matrix held as one memory row per vertex. Depends on uat_pkg,
// uat_front, uat_cmd_queue and uat_back.
//
// Input channel in_valid/in_ready carries in_op, in_vertex_a and in_vertex_b;
// each accepted item gives exactly one item on out_valid/out_ready with out_ok.
// The intake register and a two-entry command queue decouple intake from the
// execution engine, so items are taken while a result waits to be collected.
// An accepted item passes through the intake register, the command queue and
// the engine before its result is registered on out_valid.
// The engine handles one command at a time: add vertex and refusals are
// settled straight from the idle state, edges read-modify-write the first
// endpoint's row and then, unless it is a self-loop, the second endpoint's
// row, and vertex removal sweeps every row once to clear the vertex's column.
// Reset (rst_n low, synchronous) clears all present bits and marks every
// adjacency row as unwritten, so rows read as zero; no clearing pass is needed.
// While out_ready is low the result is held and the engine takes no further
// command; intake continues until the queue and intake register are full.
module undirected_adjacency_table
  import uat_pkg::*;
#(
  parameter int NUM_VERTICES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_vertex_a,
  input  logic [7:0] in_vertex_b,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_ok
);

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  uat_front #(
    .NUM_VERTICES(NUM_VERTICES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_vertex_a(in_vertex_a),
    .in_vertex_b(in_vertex_b),
    .cmd_valid  (fr_valid),
    .cmd_ready  (fr_ready),
    .cmd        (fr_cmd)
  );

  uat_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fr_valid),
    .push_ready(fr_ready),
    .push_cmd  (fr_cmd),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_cmd   (q_cmd)
  );

  uat_back #(
    .NUM_VERTICES(NUM_VERTICES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(q_valid),
    .cmd_ready(q_ready),
    .cmd      (q_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_ok   (out_ok)
  );

endmodule
